// ===== sv/fptq_pkg.sv =====
// ----------------------------------------------------------------------------
// fptq_pkg: shared types and constants of the paced transmit queue
// Queue geometry, field widths, register indexes and the item kinds.
// ----------------------------------------------------------------------------
package fptq_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int TAG_W       = 16;
	localparam int DUR_W       = 16;
	localparam int SPACE_W     = 16;
	localparam int DELAY_W     = 24;
	localparam int FACTOR_W    = 7;
	localparam int PCT_W       = 7;
	localparam int PERIOD_W    = 8;
	localparam int ENTRY_W     = TAG_W + DUR_W;
	// The gap timer holds duration * (100 + factor), a hundred per tick.
	localparam int TIMER_W     = DUR_W + 8;

	localparam int IN_DATA_W   = 88;
	localparam int OUT_DATA_W  = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8;

	localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_MARK    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_MARK     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_PERIOD = 2'd3;

	localparam logic [FACTOR_W-1:0] FACTOR_MAX = 7'd100;
	localparam logic [TIMER_W-1:0]  TICK_UNIT  = 24'd100;
	localparam logic [TIMER_W-1:0]  EXPIRE_LIM = 24'd200;

	typedef enum logic [1:0] {
		MODE_DATA     = 2'd0,
		MODE_FEEDBACK = 2'd1,
		MODE_TICK     = 2'd2
	} mode_t;

	typedef struct packed {
		logic [CNT_W-1:0]    queue_count;
		logic [FACTOR_W-1:0] rate_factor;
		logic                dropped;
		logic [TAG_W-1:0]    sent_tag;
		logic                sent;
	} result_t;

endpackage

// ===== sv/feedback_paced_tx_queue_top.sv =====
// ----------------------------------------------------------------------------
// feedback_paced_tx_queue_top: paced transmit queue with feedback slow-down
// A result item is registered, ready the cycle after its input is accepted.
// Throughput: one item per cycle unless the output stalls; the head entry is
// read ahead from the packet memory, bypassed while that entry is written.
// Reset (arst_n low) empties the queue, idles the sender and restores the
// register defaults at once; the packet memory itself is not cleared.
// ----------------------------------------------------------------------------
module feedback_paced_tx_queue_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// packet_tag, packet_duration, total_space, free_space, feedback_delay
	input  logic [fptq_pkg::IN_DATA_W-1:0]    s_tdata,
	// mode
	input  logic [1:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// sent, sent_tag, dropped, rate_factor, queue_count
	output logic [fptq_pkg::OUT_DATA_W-1:0]   m_tdata,
	input  logic                              cfg_we,
	input  logic [fptq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fptq_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int PW = fptq_pkg::PTR_W;
	localparam int CW = fptq_pkg::CNT_W;
	localparam int TW = fptq_pkg::TIMER_W;
	localparam int DW = fptq_pkg::DELAY_W;
	localparam int FW = fptq_pkg::FACTOR_W;

	// Configuration registers
	logic [fptq_pkg::CFG_DATA_W-2:0] queue_limit_q;
	logic [fptq_pkg::PCT_W-1:0]      high_mark_q;
	logic [fptq_pkg::PCT_W-1:0]      low_mark_q;
	logic [fptq_pkg::PERIOD_W-1:0]   reset_period_q;

	// Queue and pacing state
	logic [PW-1:0]                   head_q, tail_q;
	logic [CW-1:0]                   fill_q;
	logic                            busy_q;
	logic [TW-1:0]                   timer_q;
	logic [FW-1:0]                   slow_q;
	logic [DW-1:0]                   min_delay_q;
	logic [fptq_pkg::PERIOD_W-1:0]   fb_count_q;

	logic [PW-1:0]                   head_n, tail_n;
	logic [CW-1:0]                   fill_n;
	logic                            busy_n;
	logic [TW-1:0]                   timer_n;
	logic [FW-1:0]                   slow_n;
	logic [DW-1:0]                   min_delay_n;
	logic [fptq_pkg::PERIOD_W-1:0]   fb_count_n;

	// Packet memory and its registered read port
	logic [fptq_pkg::ENTRY_W-1:0]    mem [fptq_pkg::QUEUE_DEPTH];
	logic [fptq_pkg::ENTRY_W-1:0]    rd_s1;
	logic [fptq_pkg::ENTRY_W-1:0]    wdata_q;
	logic                            fwd_q;
	logic [fptq_pkg::ENTRY_W-1:0]    wdata;
	logic                            wr_en;
	logic [PW-1:0]                   rd_addr;
	logic [fptq_pkg::ENTRY_W-1:0]    head_entry;

	// Input fields
	fptq_pkg::mode_t                 mode;
	logic [fptq_pkg::TAG_W-1:0]      in_tag;
	logic [fptq_pkg::DUR_W-1:0]      in_dur;
	logic [fptq_pkg::SPACE_W-1:0]    in_total;
	logic [fptq_pkg::SPACE_W-1:0]    in_free;
	logic [DW-1:0]                   in_delay;

	logic                            accept;
	logic [CW-1:0]                   limit;
	logic                            do_send;
	logic [fptq_pkg::DUR_W-1:0]      send_dur;
	logic [fptq_pkg::TAG_W-1:0]      send_tag;
	logic [TW-1:0]                   reload;
	logic                            drop;

	// Feedback arithmetic
	logic [DW-1:0]                   md0;
	logic [22:0]                     free_x100, high_x_total, low_x_total;
	logic                            sp_up, sp_dn, dl_up, dl_dn;
	logic signed [9:0]               f_sum;
	logic [fptq_pkg::PERIOD_W-1:0]   cnt_inc;
	logic                            clear_hit;

	fptq_pkg::result_t               res;
	fptq_pkg::result_t               res_q;
	logic                            m_tvalid_q;

	assign mode     = fptq_pkg::mode_t'(s_tuser);
	assign in_tag   = s_tdata[15:0];
	assign in_dur   = s_tdata[31:16];
	assign in_total = s_tdata[47:32];
	assign in_free  = s_tdata[63:48];
	assign in_delay = s_tdata[87:64];

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign limit = (queue_limit_q > CW'(fptq_pkg::QUEUE_DEPTH)) ?
		CW'(fptq_pkg::QUEUE_DEPTH) : CW'(queue_limit_q);

	assign head_entry = fwd_q ? wdata_q : rd_s1;
	assign wdata      = {in_dur, in_tag};

	assign reload = TW'(send_dur) * TW'(8'd100 + {1'b0, slow_q});

	// Feedback terms
	assign md0          = (min_delay_q == '0) ? in_delay : min_delay_q;
	assign free_x100    = 23'(in_free) * 23'd100;
	assign high_x_total = 23'(high_mark_q) * 23'(in_total);
	assign low_x_total  = 23'(low_mark_q) * 23'(in_total);
	assign sp_up        = free_x100 >= high_x_total;
	assign sp_dn        = !sp_up && (free_x100 <= low_x_total);
	assign dl_up        = {1'b0, in_delay} >= {md0, 1'b0};
	assign dl_dn        = !dl_up && (in_delay <= md0);
	assign f_sum        = $signed({3'b000, slow_q})
		+ $signed({9'd0, sp_up}) + $signed({9'd0, dl_up})
		- $signed({9'd0, sp_dn}) - $signed({9'd0, dl_dn});
	assign cnt_inc      = fb_count_q + 8'd1;
	assign clear_hit    = (reset_period_q == '0) ? (cnt_inc == '0)
		: (cnt_inc >= reset_period_q);

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(fptq_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_comb begin
		head_n      = head_q;
		tail_n      = tail_q;
		fill_n      = fill_q;
		busy_n      = busy_q;
		timer_n     = timer_q;
		slow_n      = slow_q;
		min_delay_n = min_delay_q;
		fb_count_n  = fb_count_q;
		wr_en       = 1'b0;
		do_send     = 1'b0;
		drop        = 1'b0;
		send_dur    = head_entry[fptq_pkg::ENTRY_W-1:fptq_pkg::TAG_W];
		send_tag    = head_entry[fptq_pkg::TAG_W-1:0];
		case (mode)
			fptq_pkg::MODE_DATA: begin
				if (fill_q >= limit) begin
					drop = 1'b1;
				end else begin
					wr_en  = 1'b1;
					tail_n = ptr_inc(tail_q);
					if (!busy_q) begin
						// An idle sender has an empty queue: the new packet leaves at once.
						do_send  = 1'b1;
						send_dur = in_dur;
						send_tag = in_tag;
						head_n   = ptr_inc(head_q);
						busy_n   = 1'b1;
						timer_n  = reload;
					end else begin
						fill_n = fill_q + CW'(1);
					end
				end
			end
			fptq_pkg::MODE_FEEDBACK: begin
				min_delay_n = dl_dn ? in_delay : md0;
				if (f_sum > 10'sd100)
					slow_n = fptq_pkg::FACTOR_MAX;
				else if (f_sum < 10'sd0)
					slow_n = '0;
				else
					slow_n = FW'(f_sum);
				if (clear_hit) begin
					min_delay_n = '0;
					fb_count_n  = '0;
				end else begin
					fb_count_n = cnt_inc;
				end
			end
			fptq_pkg::MODE_TICK: begin
				if (busy_q) begin
					// The timer counts in hundredths: under two ticks left means expiry.
					if (timer_q < fptq_pkg::EXPIRE_LIM) begin
						if (fill_q != '0) begin
							do_send = 1'b1;
							head_n  = ptr_inc(head_q);
							fill_n  = fill_q - CW'(1);
							timer_n = reload;
						end else begin
							busy_n  = 1'b0;
							timer_n = '0;
						end
					end else begin
						timer_n = timer_q - fptq_pkg::TICK_UNIT;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign rd_addr = accept ? head_n : head_q;

	always_comb begin
		res.sent        = do_send;
		res.sent_tag    = do_send ? send_tag : '0;
		res.dropped     = drop;
		res.rate_factor = slow_n;
		res.queue_count = fill_n;
	end

	always_ff @(posedge clk) begin
		if (accept && wr_en)
			mem[tail_q] <= wdata;
		rd_s1   <= mem[rd_addr];
		fwd_q   <= accept && wr_en && (tail_q == rd_addr);
		wdata_q <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queue_limit_q  <= 7'd64;
			high_mark_q    <= 7'd70;
			low_mark_q     <= 7'd40;
			reset_period_q <= 8'd50;
		end else if (cfg_we) begin
			case (cfg_index)
				fptq_pkg::REG_QUEUE_LIMIT:  queue_limit_q  <= cfg_data[6:0];
				fptq_pkg::REG_HIGH_MARK:    high_mark_q    <= cfg_data[6:0];
				fptq_pkg::REG_LOW_MARK:     low_mark_q     <= cfg_data[6:0];
				fptq_pkg::REG_RESET_PERIOD: reset_period_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			fill_q      <= '0;
			busy_q      <= 1'b0;
			timer_q     <= '0;
			slow_q      <= '0;
			min_delay_q <= '0;
			fb_count_q  <= '0;
		end else if (accept) begin
			head_q      <= head_n;
			tail_q      <= tail_n;
			fill_q      <= fill_n;
			busy_q      <= busy_n;
			timer_q     <= timer_n;
			slow_q      <= slow_n;
			min_delay_q <= min_delay_n;
			fb_count_q  <= fb_count_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (accept) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			res_q <= res;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = res_q;

endmodule

// ===== sv/fptq_checker.sv =====
// ----------------------------------------------------------------------------
// fptq_checker: port-level checks of the paced transmit queue
// Watches the stream ports and flags result items that cannot occur.
// ----------------------------------------------------------------------------
module fptq_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [fptq_pkg::OUT_DATA_W-1:0]   m_tdata
);

	// Every accepted item yields a result item in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> m_tvalid)
		else $error("accepted item produced no result item");

	// With no result pending the input side is never held off.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while output register empty");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result item changed");

	// A packet is never both sent and dropped; counts stay in range.
	a_result_sane: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!(m_tdata[0] && m_tdata[17]) && (m_tdata[24:18] <= 7'd100)
			&& (m_tdata[31:25] <= 7'd64) && (m_tdata[0] || (m_tdata[16:1] == 16'd0))))
		else $error("result item fields out of range");

endmodule

bind feedback_paced_tx_queue_top fptq_checker u_fptq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the paced transmit queue
// An item-level predictor of the queue, the gap timer and the feedback-driven
// slow-down factor runs beside the block. Every item accepted on the input
// stream yields one expected report, and each report leaving the block is
// compared field by field with the oldest expectation. Directed items come
// first, then the factor is driven into both clamps, the queue is filled
// under a long output stall, and random traffic runs under several register
// settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb;
	import fptq_pkg::*;

	localparam logic [1:0] MODE_SPARE     = 2'd3;
	localparam int         HOLD_CYCLES    = 300;
	localparam int         WATCHDOG_LIMIT = 4000;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	// packet_tag, packet_duration, total_space, free_space, feedback_delay
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	// mode
	logic [1:0]            s_tuser   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	// sent, sent_tag, dropped, rate_factor, queue_count
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	feedback_paced_tx_queue_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predicted state of the queue, the pacer and the registers.
	logic [TAG_W-1:0] held_tag [QUEUE_DEPTH];
	logic [DUR_W-1:0] held_dur [QUEUE_DEPTH];
	int unsigned      head_idx, tail_idx, held_count, gap_ticks, factor_pct, fb_seen;
	bit               sending;
	longint unsigned  min_seen_delay;
	int unsigned      lim_cfg, high_cfg, low_cfg, period_cfg;

	result_t          pending_reports[$];
	result_t          got, want;
	int               fail_count;
	int               data_items, feedback_items, tick_items, spare_items;
	int               sent_seen, drop_seen, settings_used;

	int               burst_left;
	bit               steady_sender;
	int unsigned      hold_requested, hold_acked, hold_left;
	int unsigned      window_left, stall_style;
	logic [7:0]       stall_mask;
	int unsigned      stalled_cycles;

	function automatic logic [IN_DATA_W-1:0] pack_item(logic [TAG_W-1:0] tag,
			logic [DUR_W-1:0] dur, logic [SPACE_W-1:0] total,
			logic [SPACE_W-1:0] free, logic [DELAY_W-1:0] delay);
		return {delay, free, total, dur, tag};
	endfunction

	// Takes the head packet off the queue and loads the gap for it.
	function automatic logic [TAG_W-1:0] launch_head();
		logic [TAG_W-1:0] tag;
		tag = held_tag[head_idx];
		gap_ticks = (32'(held_dur[head_idx]) * (100 + factor_pct)) / 100;
		head_idx = (head_idx + 1) % QUEUE_DEPTH;
		held_count--;
		sending = 1'b1;
		return tag;
	endfunction

	function automatic result_t advance_pacer(logic [1:0] kind, logic [IN_DATA_W-1:0] d);
		result_t         r;
		int unsigned     limit, nxt;
		int              f;
		longint unsigned tot, fr, dl;
		bit              hit;
		r = '0;
		case (kind)
			MODE_DATA: begin
				limit = (lim_cfg > QUEUE_DEPTH) ? QUEUE_DEPTH : lim_cfg;
				if (held_count >= limit) begin
					r.dropped = 1'b1;
				end else begin
					held_tag[tail_idx] = d[TAG_W-1:0];
					held_dur[tail_idx] = d[TAG_W +: DUR_W];
					tail_idx = (tail_idx + 1) % QUEUE_DEPTH;
					held_count++;
					if (!sending) begin
						r.sent_tag = launch_head();
						r.sent = 1'b1;
					end
				end
			end
			MODE_FEEDBACK: begin
				tot = 64'(d[32 +: SPACE_W]);
				fr  = 64'(d[48 +: SPACE_W]);
				dl  = 64'(d[64 +: DELAY_W]);
				f = factor_pct;
				if (min_seen_delay == 0)
					min_seen_delay = dl;
				if (fr * 100 >= longint'(high_cfg) * tot)
					f++;
				else if (fr * 100 <= longint'(low_cfg) * tot)
					f--;
				if (dl >= 2 * min_seen_delay) begin
					f++;
				end else if (dl <= min_seen_delay) begin
					f--;
					min_seen_delay = dl;
				end
				if (f > 100)
					f = 100;
				if (f < 0)
					f = 0;
				factor_pct = f;
				nxt = (fb_seen + 1) & 8'hFF;
				// A period of zero clears only when the 8-bit count wraps.
				hit = (period_cfg == 0) ? (nxt == 0) : (nxt >= period_cfg);
				if (hit) begin
					min_seen_delay = 0;
					nxt = 0;
				end
				fb_seen = nxt;
			end
			MODE_TICK: begin
				if (sending) begin
					if (gap_ticks <= 1) begin
						if (held_count > 0) begin
							r.sent_tag = launch_head();
							r.sent = 1'b1;
						end else begin
							sending = 1'b0;
							gap_ticks = 0;
						end
					end else begin
						gap_ticks--;
					end
				end
			end
			default: ;
		endcase
		r.rate_factor = factor_pct[FACTOR_W-1:0];
		r.queue_count = held_count[CNT_W-1:0];
		return r;
	endfunction

	task automatic send_item(input logic [1:0] kind, input logic [IN_DATA_W-1:0] payload);
		int gap;
		if (!steady_sender) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(24, 1);
				if ($urandom_range(4) == 0)
					gap = 0;
				else if ($urandom_range(2) == 0)
					gap = $urandom_range(10, 4);
				else
					gap = $urandom_range(3, 1);
				if (gap > 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= payload;
		do @(posedge clk); while (!s_tready);
		pending_reports.push_back(advance_pacer(kind, payload));
		case (kind)
			MODE_DATA:     data_items++;
			MODE_FEEDBACK: feedback_items++;
			MODE_TICK:     tick_items++;
			default:       spare_items++;
		endcase
	endtask

	// Ticks until the sender has gone idle with nothing queued.
	task automatic drain_queue();
		while (sending || held_count != 0)
			send_item(MODE_TICK, pack_item(TAG_W'($urandom), DUR_W'($urandom),
				SPACE_W'($urandom), SPACE_W'($urandom), DELAY_W'($urandom)));
	endtask

	task automatic wait_quiet();
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_config(input logic [7:0] limit, input logic [7:0] high,
			input logic [7:0] low, input logic [7:0] period);
		logic [7:0] vals [4];
		int         i;
		vals = '{limit, high, low, period};
		wait_quiet();
		for (i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= i[CFG_IDX_W-1:0];
			cfg_data  <= vals[i];
			@(posedge clk);
			case (i[CFG_IDX_W-1:0])
				REG_QUEUE_LIMIT: lim_cfg  = 32'(vals[i][6:0]);
				REG_HIGH_MARK:   high_cfg = 32'(vals[i][6:0]);
				REG_LOW_MARK:    low_cfg  = 32'(vals[i][6:0]);
				default:         period_cfg = 32'(vals[i]);
			endcase
		end
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Offers a run of packets back to back so the queue reaches its limit.
	task automatic fill_and_drain(input int count, input bit with_hold);
		int i;
		steady_sender = 1'b1;
		if (with_hold)
			hold_requested <= hold_requested + 1;
		for (i = 0; i < count; i++)
			send_item(MODE_DATA, pack_item(TAG_W'($urandom), DUR_W'($urandom_range(3)),
				SPACE_W'($urandom), SPACE_W'($urandom), DELAY_W'($urandom)));
		steady_sender = 1'b0;
		drain_queue();
	endtask

	task automatic run_traffic(input int count);
		int               done, pick, pct;
		logic [1:0]       kind;
		logic [DUR_W-1:0] dur;
		logic [SPACE_W-1:0] total, free;
		logic [DELAY_W-1:0] delay;
		longint           tmp;
		int unsigned      limit;
		done = 0;
		while (done < count) begin
			pick = $urandom_range(99);
			kind = (pick < 35) ? MODE_DATA : (pick < 80) ? MODE_TICK :
				(pick < 95) ? MODE_FEEDBACK : MODE_SPARE;
			limit = (lim_cfg > QUEUE_DEPTH) ? QUEUE_DEPTH : lim_cfg;
			// Packets that will be dropped carry full-range durations.
			if (held_count >= limit)
				dur = DUR_W'($urandom);
			else if ($urandom_range(19) == 0)
				dur = DUR_W'($urandom_range(400, 41));
			else if ($urandom_range(3) == 0)
				dur = DUR_W'($urandom_range(40, 4));
			else
				dur = DUR_W'($urandom_range(3));
			case ($urandom_range(3))
				0:       total = SPACE_W'($urandom);
				1:       total = SPACE_W'(100 * $urandom_range(655));
				2:       total = SPACE_W'($urandom_range(20));
				default: total = 16'hFFFF;
			endcase
			pick = $urandom_range(4);
			if (pick == 0) begin
				free = SPACE_W'($urandom);
			end else begin
				pct = (pick == 1) ? high_cfg : (pick == 2) ? low_cfg : $urandom_range(100);
				tmp = (longint'(total) * pct) / 100 + $urandom_range(2) - 1;
				free = (tmp < 0) ? 16'd0 : (tmp > 65535) ? 16'hFFFF : tmp[15:0];
			end
			case ($urandom_range(6))
				0:       delay = '0;
				1:       delay = DELAY_W'(min_seen_delay);
				2:       delay = DELAY_W'(min_seen_delay - 1);
				3:       delay = DELAY_W'(2 * min_seen_delay);
				4:       delay = DELAY_W'(2 * min_seen_delay - 1);
				5:       delay = DELAY_W'(min_seen_delay + $urandom_range(50));
				default: delay = DELAY_W'($urandom);
			endcase
			send_item(kind, pack_item(TAG_W'($urandom), dur, total, free, delay));
			if (kind != MODE_SPARE)
				done++;
		end
	endtask

	task automatic test_directed();
		send_item(MODE_TICK, pack_item(16'h0, 16'h0, 16'h0, 16'h0, 24'h0));
		send_item(MODE_SPARE, '1);
		send_item(MODE_DATA, pack_item(16'h0000, 16'd0, 16'h0, 16'h0, 24'h0));
		send_item(MODE_TICK, '0);
		send_item(MODE_DATA, pack_item(16'hFFFF, 16'd1, 16'h0, 16'h0, 24'h0));
		send_item(MODE_DATA, pack_item(16'h1234, 16'd2, 16'h0, 16'h0, 24'h0));
		send_item(MODE_TICK, '0);
		send_item(MODE_DATA, pack_item(16'hABCD, 16'd0, 16'h0, 16'h0, 24'h0));
		send_item(MODE_TICK, '0);
		send_item(MODE_TICK, '0);
		send_item(MODE_TICK, '0);
		// An unset minimum takes the first delay, so a zero delay reads as congestion.
		send_item(MODE_FEEDBACK, pack_item(16'h0, 16'h0, 16'h0, 16'h0, 24'h0));
		send_item(MODE_FEEDBACK, pack_item(16'h0, 16'h0, 16'hFFFF, 16'hFFFF, 24'hFFFFFF));
		send_item(MODE_FEEDBACK, pack_item(16'h0, 16'h0, 16'hFFFF, 16'h0, 24'd1));
		send_item(MODE_FEEDBACK, pack_item(16'h0, 16'h0, 16'd100, 16'd70, 24'd3));
		send_item(MODE_FEEDBACK, pack_item(16'h0, 16'h0, 16'd100, 16'd40, 24'd6));
		send_item(MODE_FEEDBACK, pack_item(16'h0, 16'h0, 16'd100, 16'd69, 24'd2));
		send_item(MODE_SPARE, '0);
	endtask

	task automatic test_factor_saturation();
		int i;
		for (i = 0; i < 54; i++)
			send_item(MODE_FEEDBACK, pack_item(TAG_W'($urandom), DUR_W'($urandom),
				16'd1000, 16'd1000, 24'd0));
		// With the factor at its ceiling the reload doubles the duration.
		send_item(MODE_DATA, pack_item(16'h5A5A, 16'd10, 16'h0, 16'h0, 24'h0));
		send_item(MODE_DATA, pack_item(16'hA5A5, 16'd7, 16'h0, 16'h0, 24'h0));
		drain_queue();
		for (i = 0; i < 54; i++)
			send_item(MODE_FEEDBACK, pack_item(TAG_W'($urandom), DUR_W'($urandom),
				16'd1000, 16'd0, 24'd7));
	endtask

	task automatic test_queue_pressure();
		fill_and_drain(70, 1'b1);
	endtask

	task automatic test_register_sweep();
		set_config(8'd4, 8'd100, 8'd0, 8'd1);
		run_traffic(40);
		set_config(8'd0, 8'd0, 8'd100, 8'd255);
		run_traffic(40);
		// Only the low seven bits of the limit are kept, giving a limit of two.
		set_config(8'd130, 8'd50, 8'd50, 8'd0);
		run_traffic(40);
		set_config(8'd127, 8'd85, 8'd20, 8'd3);
		fill_and_drain(70, 1'b0);
		run_traffic(40);
		set_config(8'd1, 8'd228, 8'd1, 8'd2);
		run_traffic(40);
		set_config(8'd64, 8'd70, 8'd40, 8'd50);
		run_traffic(50);
	endtask

	// Output side: a changing stall pattern, plus a long hold when requested.
	always @(posedge clk) begin
		if (hold_acked != hold_requested) begin
			hold_acked <= hold_requested;
			hold_left  <= HOLD_CYCLES;
			m_tready   <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (window_left == 0) begin
			window_left <= $urandom_range(64, 16);
			stall_style <= $urandom_range(3);
			stall_mask  <= 8'($urandom) | 8'h01;
			m_tready    <= 1'b1;
		end else begin
			window_left <= window_left - 1;
			case (stall_style)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(1));
				2: begin
					m_tready   <= stall_mask[0];
					stall_mask <= {stall_mask[0], stall_mask[7:1]};
				end
				default: m_tready <= ($urandom_range(3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'(m_tdata);
			if (pending_reports.size() == 0) begin
				$error("report with no item waiting for it: %h", m_tdata);
				fail_count++;
			end else begin
				want = pending_reports.pop_front();
				if (got.sent !== want.sent) begin
					$error("sent: expected %0d, got %0d", want.sent, got.sent);
					fail_count++;
				end
				if (got.sent_tag !== want.sent_tag) begin
					$error("sent_tag: expected %h, got %h", want.sent_tag, got.sent_tag);
					fail_count++;
				end
				if (got.dropped !== want.dropped) begin
					$error("dropped: expected %0d, got %0d", want.dropped, got.dropped);
					fail_count++;
				end
				if (got.rate_factor !== want.rate_factor) begin
					$error("rate_factor: expected %0d, got %0d", want.rate_factor,
						got.rate_factor);
					fail_count++;
				end
				if (got.queue_count !== want.queue_count) begin
					$error("queue_count: expected %0d, got %0d", want.queue_count,
						got.queue_count);
					fail_count++;
				end
			end
			sent_seen += int'(got.sent);
			drop_seen += int'(got.dropped);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			stalled_cycles <= 0;
		else
			stalled_cycles <= stalled_cycles + 1;
	end

	initial begin
		while (stalled_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("[feedback_paced_tx_queue_top] ERROR");
		$finish;
	end

	initial begin
		head_idx       = 0;
		tail_idx       = 0;
		held_count     = 0;
		sending        = 1'b0;
		gap_ticks      = 0;
		factor_pct     = 0;
		min_seen_delay = 0;
		fb_seen        = 0;
		lim_cfg        = 64;
		high_cfg       = 70;
		low_cfg        = 40;
		period_cfg     = 50;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_factor_saturation();
		test_queue_pressure();
		test_register_sweep();

		wait_quiet();
		$display("Covered %0d items: %0d packets, %0d feedback reports, %0d ticks, %0d spare.",
			data_items + feedback_items + tick_items + spare_items, data_items,
			feedback_items, tick_items, spare_items);
		$display("Packets sent %0d, dropped %0d, under %0d register settings beyond reset.",
			sent_seen, drop_seen, settings_used);
		if (fail_count == 0)
			$display("[feedback_paced_tx_queue_top] OK");
		else
			$display("[feedback_paced_tx_queue_top] ERROR");
		$finish;
	end

endmodule

// ===== feedback_paced_tx_queue_top.f =====
sv/fptq_pkg.sv
sv/feedback_paced_tx_queue_top.sv
sv/fptq_checker.sv
tb/tb.sv
